/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define QP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be true outside reset
`define QP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define QP_ASSERT(lbl, clk, rst_n, prop)
`define QP_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/qpht_pkg.sv */
package qpht_pkg;

  localparam int KEY_IN_W = 32;
  localparam int COLOR_W  = 8;
  localparam int DIST_W   = 32;
  localparam int SLOT_W   = 13;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_STORE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    RES_HIT  = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2,
    RES_DONE = 2'd3
  } result_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_CLR_DONE,
    S_MOD,
    S_START,
    S_PROBE
  } ctrl_state_e;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [DIST_W-1:0]  distance;
  } value_t;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [KEY_IN_W-1:0] key;
    value_t              value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    value_t            value;
  } rsp_t;

  typedef struct packed {
    logic    capture;
    logic    sweep_start;
    logic    sweep_step;
    logic    mod_step;
    logic    probe_start;
    logic    probe_next;
    logic    write;
    logic    emit;
    logic    use_slot;
    result_e res;
  } cmd_t;

  typedef struct packed {
    logic    sweep_last;
    logic    mod_last;
    logic    slot_empty;
    logic    key_match;
    logic    probe_last;
    logic    out_free;
    opcode_e op_in;
    opcode_e op;
  } sts_t;

endpackage

/* rtl/qpht_if.sv */
interface qpht_in_if import qpht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [KEY_IN_W-1:0] key;
  logic [COLOR_W-1:0]  red_in;
  logic [COLOR_W-1:0]  green_in;
  logic [COLOR_W-1:0]  blue_in;
  logic [DIST_W-1:0]   distance_in;

  modport source (
    output valid, opcode, key, red_in, green_in, blue_in, distance_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, key, red_in, green_in, blue_in, distance_in,
    output ready
  );
endinterface

interface qpht_out_if import qpht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  slot;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic [DIST_W-1:0]  distance_out;

  modport source (
    output valid, status, slot, red_out, green_out, blue_out, distance_out,
    input  ready
  );
  modport sink (
    input  valid, status, slot, red_out, green_out, blue_out, distance_out,
    output ready
  );
endinterface

/* rtl/qpht_mod.sv */
module qpht_mod import qpht_pkg::*; #(
  parameter int TABLE_SIZE = 8191,
  parameter int KEY_W      = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [KEY_W-1:0]              key_i,
  input  logic                          step_i,
  output logic [$clog2(TABLE_SIZE)-1:0] rem_o,
  output logic                          last_o
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [KEY_IN_W-1:0] TBL_M = KEY_IN_W'(TABLE_SIZE);
  // floor(2^32 / size): the estimated quotient is low by at most one
  localparam logic [KEY_IN_W-1:0] RECIP =
    KEY_IN_W'((64'd1 << KEY_IN_W) / 64'(TABLE_SIZE));

  logic [KEY_IN_W-1:0]   key_q, key_d;
  logic [2*KEY_IN_W-1:0] acc_q, acc_d;
  logic [IDX_W-1:0]      rem_q, rem_d;
  logic [2:0]            stg_q, stg_d;
  logic [KEY_IN_W-1:0]   diff;

  // stage 0 multiplies by the reciprocal, stage 1 multiplies the quotient
  // back, stage 2 subtracts and corrects once
  always_comb begin
    key_d = key_q;
    acc_d = acc_q;
    rem_d = rem_q;
    stg_d = stg_q;
    diff  = key_q - acc_q[KEY_IN_W-1:0];
    if (diff >= TBL_M) begin
      diff = diff - TBL_M;
    end
    if (load_i) begin
      key_d = KEY_IN_W'(key_i);
      acc_d = '0;
      rem_d = '0;
      stg_d = 3'b001;
    end else if (step_i) begin
      stg_d = {stg_q[1:0], 1'b0};
      if (stg_q[0]) begin
        acc_d = key_q * RECIP;
      end
      if (stg_q[1]) begin
        acc_d = {{KEY_IN_W{1'b0}}, acc_q[2*KEY_IN_W-1:KEY_IN_W] * TBL_M};
      end
      if (stg_q[2]) begin
        rem_d = diff[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      stg_q <= '0;
    end else begin
      rem_q <= rem_d;
      stg_q <= stg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    acc_q <= acc_d;
  end

  assign rem_o  = rem_q;
  assign last_o = stg_q[2];

endmodule

/* rtl/qpht_ctrl.sv */
`include "assert_macros.svh"

module qpht_ctrl import qpht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res  = RES_DONE;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.op_in == OP_CLEAR) begin
            cmd_o.sweep_start = 1'b1;
            state_d           = S_CLEAR;
          end else begin
            state_d = S_MOD;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_CLR_DONE;
        end
      end
      S_CLR_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = RES_DONE;
          state_d    = S_IDLE;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.probe_start = 1'b1;
        state_d           = S_PROBE;
      end
      S_PROBE: begin
        // without probe_next the slot is read again while the output is busy
        if (sts_i.slot_empty || sts_i.key_match) begin
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.use_slot = 1'b1;
            if (sts_i.op == OP_STORE) begin
              cmd_o.write = 1'b1;
              cmd_o.res   = RES_DONE;
            end else if (sts_i.slot_empty) begin
              cmd_o.res = RES_MISS;
            end else begin
              cmd_o.res = RES_HIT;
            end
            state_d = S_IDLE;
          end
        end else if (sts_i.probe_last) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.res  = RES_FULL;
            state_d    = S_IDLE;
          end
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  `QP_ASSERT(a_busy_after_accept, clk_i, rst_ni, (state_q == S_IDLE && in_valid_i) |=> state_q != S_IDLE)
  `QP_ASSERT_NEVER(a_emit_blocked, clk_i, rst_ni, cmd_o.emit && !sts_i.out_free)
  `QP_ASSERT(a_write_only_store, clk_i, rst_ni, cmd_o.write |-> (sts_i.op == OP_STORE && cmd_o.emit))

endmodule

/* rtl/qpht_datapath.sv */
`include "assert_macros.svh"

module qpht_datapath import qpht_pkg::*; #(
  parameter int TABLE_SIZE = 8191,
  parameter int KEY_BITS   = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  input  logic out_ready_i,
  output sts_t sts_o,
  output logic out_valid_o,
  output rsp_t rsp_o
);

  localparam int KEY_W = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W:0]   TBL_M    = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  opcode_e          op_q;
  logic [KEY_W-1:0] key_q;
  value_t           val_q;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic [IDX_W-1:0] rem;
  logic             mod_last;
  logic [IDX_W:0]   idx_sum, step_sum;

  logic [KEY_W-1:0] key_mem [TABLE_SIZE];
  value_t           val_mem [TABLE_SIZE];
  logic             vld_mem [TABLE_SIZE];
  logic [KEY_W-1:0] key_rd_q;
  value_t           val_rd_q;
  logic             vld_rd_q;
  logic             vld_we, vld_wd;
  logic [IDX_W-1:0] vld_wa;

  logic             out_valid_q;
  rsp_t             rsp_q;
  logic             out_free;

  qpht_mod #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_W      (KEY_W)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cmd_i.capture),
    .key_i  (req_i.key[KEY_W-1:0]),
    .step_i (cmd_i.mod_step),
    .rem_o  (rem),
    .last_o (mod_last)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_e'(req_i.opcode);
      key_q <= req_i.key[KEY_W-1:0];
      val_q <= req_i.value;
    end
  end

  // next slot and next increment (odd numbers reduced modulo the table size), both kept below the table size
  always_comb begin
    idx_sum  = {1'b0, idx_q} + {1'b0, step_q};
    if (idx_sum >= TBL_M) begin
      idx_sum = idx_sum - TBL_M;
    end
    step_sum = {1'b0, step_q} + (IDX_W+1)'(2);
    if (step_sum >= TBL_M) begin
      step_sum = step_sum - TBL_M;
    end
  end

  always_comb begin
    idx_d   = idx_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    sweep_d = sweep_q;
    if (cmd_i.probe_start) begin
      idx_d  = rem;
      step_d = IDX_W'(1);
      cnt_d  = '0;
    end else if (cmd_i.probe_next) begin
      idx_d  = idx_sum[IDX_W-1:0];
      step_d = step_sum[IDX_W-1:0];
      cnt_d  = cnt_q + 1'b1;
    end
    if (cmd_i.sweep_start) begin
      sweep_d = '0;
    end else if (cmd_i.sweep_step) begin
      sweep_d = sweep_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      step_q  <= '0;
      cnt_q   <= '0;
      sweep_q <= '0;
    end else begin
      idx_q   <= idx_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      sweep_q <= sweep_d;
    end
  end

  // the read address is the next slot, so data for idx_q is ready each cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      key_mem[idx_q] <= key_q;
      val_mem[idx_q] <= val_q;
    end
    key_rd_q <= key_mem[idx_d];
    val_rd_q <= val_mem[idx_d];
  end

  assign vld_we = cmd_i.write || cmd_i.sweep_step;
  assign vld_wd = cmd_i.write;
  assign vld_wa = cmd_i.write ? idx_q : sweep_q;

  always_ff @(posedge clk_i) begin
    if (vld_we) begin
      vld_mem[vld_wa] <= vld_wd;
    end
    vld_rd_q <= vld_mem[idx_d];
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_q.status <= cmd_i.res;
      rsp_q.slot   <= cmd_i.use_slot ? SLOT_W'(idx_q) : '0;
      rsp_q.value  <= (cmd_i.res == RES_HIT) ? val_rd_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

  assign sts_o.sweep_last = (sweep_q == LAST_IDX);
  assign sts_o.mod_last   = mod_last;
  assign sts_o.slot_empty = !vld_rd_q;
  assign sts_o.key_match  = (key_rd_q == key_q);
  assign sts_o.probe_last = (cnt_q == LAST_IDX);
  assign sts_o.out_free   = out_free;
  assign sts_o.op_in      = opcode_e'(req_i.opcode);
  assign sts_o.op         = op_q;

  `QP_ASSERT_NEVER(a_idx_range, clk_i, rst_ni, idx_q >= IDX_W'(TABLE_SIZE))
  `QP_ASSERT_NEVER(a_step_range, clk_i, rst_ni, step_q >= IDX_W'(TABLE_SIZE))
  `QP_ASSERT(a_emit_sets_valid, clk_i, rst_ni, cmd_i.emit |=> out_valid_q)

endmodule

/* rtl/quadratic_probe_hash_table.sv */
// Open-addressing hash table with quadratic probing over TABLE_SIZE slots
// (prime, 8191 by default). Each req_i item is a lookup (opcode 0, also 3),
// a store (1) or a clear (2) and yields exactly one rsp_o item: status 0 hit
// with the stored color and 16.16 distance, 1 miss with the first empty
// slot, 2 table full (slot zero), 3 stored or cleared. Items are handled one
// at a time. A lookup or store is accepted, the key-mod-size remainder unit
// runs (reciprocal multiply, multiply back, one correcting subtract), the
// probe is started, then the table memory is read once per probe, for
// 1 to TABLE_SIZE probed slots. A clear sweeps the valid store one slot per
// cycle. After reset the same clearing pass runs, and no item is accepted
// until it ends. A finished result is held in the output register while
// the next item is accepted; the block only waits there when a second
// result is ready before the first is taken.
module quadratic_probe_hash_table import qpht_pkg::*; #(
  parameter int TABLE_SIZE = 8191,
  parameter int KEY_BITS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  qpht_in_if.sink           req_i,
  qpht_out_if.source        rsp_o
);

  req_t req;
  rsp_t rsp;
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  assign req.opcode         = req_i.opcode;
  assign req.key            = req_i.key;
  assign req.value.red      = req_i.red_in;
  assign req.value.green    = req_i.green_in;
  assign req.value.blue     = req_i.blue_in;
  assign req.value.distance = req_i.distance_in;
  assign req_i.ready        = in_ready;

  qpht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  qpht_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .out_ready_i (rsp_o.ready),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .rsp_o       (rsp)
  );

  assign rsp_o.valid        = out_valid;
  assign rsp_o.status       = rsp.status;
  assign rsp_o.slot         = rsp.slot;
  assign rsp_o.red_out      = rsp.value.red;
  assign rsp_o.green_out    = rsp.value.green;
  assign rsp_o.blue_out     = rsp.value.blue;
  assign rsp_o.distance_out = rsp.value.distance;

endmodule

/* tb/tb_quadratic_probe_hash_table.sv */
`timescale 1ns / 100ps

module tb_quadratic_probe_hash_table;
  import qpht_pkg::*;

  localparam int unsigned TABLE_SIZE  = 8191;
  localparam int          RST_CYCLES  = 6;
  // longest quiet stretch: reset sweep, clear sweep or a full-table probe, several times over
  localparam int          STALL_LIMIT = 40000;
  localparam int          BURST_LEN   = 300;
  localparam int          SETTLE      = 50;
  localparam int          RAND_PER_PHASE = 377;
  localparam int          CHAIN_LEN   = 16;

  logic clk_i;
  logic rst_ni;

  qpht_in_if  req_if ();
  qpht_out_if rsp_if ();

  quadratic_probe_hash_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // shadow copy of the table
  logic [KEY_IN_W-1:0] tbl_key  [TABLE_SIZE];
  value_t              tbl_val  [TABLE_SIZE];
  bit                  tbl_used [TABLE_SIZE];

  req_t                req_backlog [$];
  rsp_t                expected_rsp [$];
  logic [KEY_IN_W-1:0] seen_keys [$];

  int  n_queued;
  int  n_accepted;
  int  fail_cnt;
  int  quiet_cycles;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  burst_left;
  bit  burst_arm;
  bit  in_fire;
  bit  out_fire;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // walk the quadratic probe path and apply the operation to the shadow table
  function automatic rsp_t probe_and_update(req_t rq);
    rsp_t        rs;
    int unsigned idx;
    int unsigned stride;
    int unsigned n;
    bit          found;
    rs = '0;
    if (rq.opcode == OP_CLEAR) begin
      foreach (tbl_used[i]) tbl_used[i] = 1'b0;
      rs.status = RES_DONE;
      return rs;
    end
    idx    = rq.key % TABLE_SIZE;
    stride = 1;
    found  = 1'b0;
    for (n = 0; n < TABLE_SIZE && !found; n++) begin
      if (!tbl_used[idx] || tbl_key[idx] == rq.key) begin
        found = 1'b1;
      end else begin
        idx    = (idx + stride) % TABLE_SIZE;
        stride = stride + 2;
      end
    end
    if (!found) begin
      rs.status = RES_FULL;
    end else if (rq.opcode == OP_STORE) begin
      tbl_key[idx]  = rq.key;
      tbl_val[idx]  = rq.value;
      tbl_used[idx] = 1'b1;
      rs.status     = RES_DONE;
      rs.slot       = idx[SLOT_W-1:0];
    end else if (tbl_used[idx]) begin
      rs.status = RES_HIT;
      rs.slot   = idx[SLOT_W-1:0];
      rs.value  = tbl_val[idx];
    end else begin
      rs.status = RES_MISS;
      rs.slot   = idx[SLOT_W-1:0];
    end
    return rs;
  endfunction

  function automatic value_t rand_value();
    value_t v;
    v.red      = $urandom;
    v.green    = $urandom;
    v.blue     = $urandom;
    v.distance = $urandom;
    return v;
  endfunction

  function automatic void push_req(opcode_e op, logic [KEY_IN_W-1:0] key, value_t v);
    req_t rq;
    rq.opcode = op;
    rq.key    = key;
    rq.value  = v;
    req_backlog.push_back(rq);
    n_queued++;
    if (op == OP_STORE) begin
      seen_keys.push_back(key);
      if (seen_keys.size() > 64) void'(seen_keys.pop_front());
    end
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic drain();
    while (n_accepted != n_queued || expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  // sender: one item held until accepted, random gaps otherwise
  always @(negedge clk_i) begin
    req_t it;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || in_fire) begin
      if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = req_backlog.pop_front();
        req_if.opcode      <= it.opcode;
        req_if.key         <= it.key;
        req_if.red_in      <= it.value.red;
        req_if.green_in    <= it.value.green;
        req_if.blue_in     <= it.value.blue;
        req_if.distance_in <= it.value.distance;
        req_if.valid       <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off when armed
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (burst_arm && burst_left == 0) begin
        burst_left = BURST_LEN;
        burst_arm  = 1'b0;
      end
      if (burst_left > 0) begin
        burst_left   = burst_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // accept, predict, compare, watchdog
  always @(posedge clk_i) begin
    req_t rq;
    rsp_t want;
    rsp_t got;
    in_fire  = rst_ni && req_if.valid && req_if.ready;
    out_fire = rst_ni && rsp_if.valid && rsp_if.ready;
    if (in_fire) begin
      rq.opcode         = req_if.opcode;
      rq.key            = req_if.key;
      rq.value.red      = req_if.red_in;
      rq.value.green    = req_if.green_in;
      rq.value.blue     = req_if.blue_in;
      rq.value.distance = req_if.distance_in;
      expected_rsp.push_back(probe_and_update(rq));
      n_accepted++;
    end
    if (out_fire) begin
      got.status         = rsp_if.status;
      got.slot           = rsp_if.slot;
      got.value.red      = rsp_if.red_out;
      got.value.green    = rsp_if.green_out;
      got.value.blue     = rsp_if.blue_out;
      got.value.distance = rsp_if.distance_out;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected item, expected none actual %0h", $time, got);
        fail_cnt++;
      end else begin
        want = expected_rsp.pop_front();
        check_field("status",   want.status,         got.status);
        check_field("slot",     want.slot,           got.slot);
        check_field("red",      want.value.red,      got.value.red);
        check_field("green",    want.value.green,    got.value.green);
        check_field("blue",     want.value.blue,     got.value.blue);
        check_field("distance", want.value.distance, got.value.distance);
      end
    end
    if (in_fire || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("tb_quadratic_probe_hash_table: FAIL");
        $finish;
      end
    end
  end

  task automatic random_phase(int n, int send_pct, int recv_pct, bit with_burst);
    int                  sel;
    int                  op_sel;
    logic [KEY_IN_W-1:0] key;
    opcode_e             op;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (with_burst) burst_arm = 1'b1;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        // colliding keys around a few home slots
        key = $urandom_range(15) * 511 + 7 + TABLE_SIZE * $urandom_range(9);
      end else if (sel < 70 && seen_keys.size() > 0) begin
        key = seen_keys[$urandom_range(seen_keys.size() - 1)];
      end else begin
        key = $urandom;
      end
      op_sel = $urandom_range(999);
      if (op_sel < 10)       op = OP_CLEAR;
      else if (op_sel < 60)  op = OP_RSVD;
      else if (op_sel < 530) op = OP_STORE;
      else                   op = OP_LOOKUP;
      push_req(op, key, rand_value());
    end
    drain();
  endtask

  initial begin
    value_t zero_v;
    value_t max_v;
    zero_v = '0;
    max_v  = '1;
    n_queued       = 0;
    n_accepted     = 0;
    fail_cnt       = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    burst_left     = 0;
    burst_arm      = 1'b0;
    in_fire        = 1'b0;
    out_fire       = 1'b0;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_LOOKUP;
    req_if.key         = '0;
    req_if.red_in      = '0;
    req_if.green_in    = '0;
    req_if.blue_in     = '0;
    req_if.distance_in = '0;
    rsp_if.ready       = 1'b0;
    rst_ni             = 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, collision chain, wrap, overwrite, reserved op, clear
    push_req(OP_LOOKUP, 32'h0, zero_v);
    push_req(OP_STORE,  32'h0, zero_v);
    push_req(OP_STORE,  32'hFFFF_FFFF, max_v);
    push_req(OP_LOOKUP, 32'h0, rand_value());
    push_req(OP_LOOKUP, 32'hFFFF_FFFF, zero_v);
    for (int k = 0; k < 4; k++) push_req(OP_STORE, 5 + TABLE_SIZE * k, rand_value());
    push_req(OP_LOOKUP, 5 + TABLE_SIZE * 3, zero_v);
    push_req(OP_LOOKUP, 5 + TABLE_SIZE * 4, zero_v);
    push_req(OP_STORE,  5, max_v);
    push_req(OP_LOOKUP, 5, zero_v);
    // second key homed at the last slot wraps past slot zero
    push_req(OP_STORE,  TABLE_SIZE - 1, rand_value());
    push_req(OP_STORE,  2 * TABLE_SIZE - 1, rand_value());
    push_req(OP_LOOKUP, 2 * TABLE_SIZE - 1, zero_v);
    push_req(OP_RSVD,   5 + TABLE_SIZE, max_v);
    push_req(OP_RSVD,   12345, max_v);
    push_req(OP_CLEAR,  32'hFFFF_FFFF, max_v);
    push_req(OP_LOOKUP, 32'h0, zero_v);
    push_req(OP_LOOKUP, 2 * TABLE_SIZE - 1, zero_v);
    drain();

    // occupy the first slots on the probe path of home slot zero, then probe past them
    for (int j = 0; j < CHAIN_LEN; j++) push_req(OP_STORE, j * j, rand_value());
    push_req(OP_LOOKUP, TABLE_SIZE, zero_v);
    push_req(OP_STORE,  TABLE_SIZE, max_v);
    push_req(OP_RSVD,   2 * TABLE_SIZE, zero_v);
    push_req(OP_LOOKUP, 1, zero_v);
    push_req(OP_LOOKUP, 3, zero_v);
    push_req(OP_CLEAR,  32'h0, zero_v);
    drain();

    random_phase(RAND_PER_PHASE, 0, 0, 1'b1);
    random_phase(RAND_PER_PHASE, 68, 0, 1'b0);
    random_phase(RAND_PER_PHASE, 0, 68, 1'b0);
    random_phase(RAND_PER_PHASE, 34, 34, 1'b0);

    repeat (SETTLE) @(posedge clk_i);
    if (fail_cnt == 0 && expected_rsp.size() == 0) begin
      $display("tb_quadratic_probe_hash_table: PASS");
    end else begin
      $display("tb_quadratic_probe_hash_table: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/qpht_pkg.sv
rtl/qpht_if.sv
rtl/qpht_mod.sv
rtl/qpht_ctrl.sv
rtl/qpht_datapath.sv
rtl/quadratic_probe_hash_table.sv
tb/tb_quadratic_probe_hash_table.sv
